// File: hdl/psra_pkg.sv
// Shared types and constants for the per-sensor running average block.
`default_nettype none
package psra_pkg;

  localparam int unsigned ValueW = 16;
  localparam int unsigned IdW    = 16;
  localparam int unsigned TimeW  = 34;
  localparam int unsigned LimitW = 15;

  localparam logic [LimitW-1:0] ValueLimitRst = 15'd17920;
  localparam logic [TimeW-1:0]  TimeLowRst    = 34'd1640000000;
  localparam logic [TimeW-1:0]  TimeHighRst   = 34'd10000000000;

  localparam logic [1:0] CfgValueLimit = 2'd0;
  localparam logic [1:0] CfgTimeLow    = 2'd1;
  localparam logic [1:0] CfgTimeHigh   = 2'd2;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusRange   = 2'd1;
  localparam logic [1:0] StatusUnknown = 2'd2;
  localparam logic [1:0] StatusFull    = 2'd3;

  localparam logic ModeLoad = 1'b0;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_REJECT = 2'd1,
    CMD_READ   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                kind;
    logic [IdW-1:0]           sensor;
    logic [IdW-1:0]           room;
    logic signed [ValueW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// File: hdl/psra_front.sv
// Front end: configuration registers, item capture and range classification.
`default_nettype none
module psra_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [1:0]                   cfg_index_i,
  input  wire logic [psra_pkg::TimeW-1:0]   cfg_data_i,
  input  wire logic                         mode_i,
  input  wire logic [psra_pkg::IdW-1:0]     sensor_id_i,
  input  wire logic [psra_pkg::IdW-1:0]     room_i,
  input  wire logic signed [psra_pkg::ValueW-1:0] reading_value_i,
  input  wire logic [psra_pkg::TimeW-1:0]   timestamp_i,
  output psra_pkg::cmd_t                    cmd_o
);

  logic [psra_pkg::LimitW-1:0] value_limit_q;
  logic [psra_pkg::TimeW-1:0]  time_low_q;
  logic [psra_pkg::TimeW-1:0]  time_high_q;
  logic signed [psra_pkg::ValueW:0] val_ext;
  logic signed [psra_pkg::ValueW:0] lim_pos;
  logic                        out_of_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_limit_q <= psra_pkg::ValueLimitRst;
      time_low_q    <= psra_pkg::TimeLowRst;
      time_high_q   <= psra_pkg::TimeHighRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        psra_pkg::CfgValueLimit: value_limit_q <= cfg_data_i[psra_pkg::LimitW-1:0];
        psra_pkg::CfgTimeLow:    time_low_q    <= cfg_data_i;
        psra_pkg::CfgTimeHigh:   time_high_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign val_ext = {reading_value_i[psra_pkg::ValueW-1], reading_value_i};
  assign lim_pos = {2'b00, value_limit_q};

  assign out_of_range = (val_ext > lim_pos) || (val_ext < -lim_pos) ||
                        (timestamp_i < time_low_q) || (timestamp_i > time_high_q);

  always_comb begin
    cmd_o.sensor = sensor_id_i;
    cmd_o.room   = room_i;
    cmd_o.value  = reading_value_i;
    if (mode_i == psra_pkg::ModeLoad) begin
      cmd_o.kind = psra_pkg::CMD_LOAD;
    end else if (out_of_range) begin
      cmd_o.kind = psra_pkg::CMD_REJECT;
    end else begin
      cmd_o.kind = psra_pkg::CMD_READ;
    end
  end

endmodule
`default_nettype wire

// File: hdl/psra_queue.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none
module psra_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  psra_pkg::q_ctrl_t   ctrl_i,
  input  psra_pkg::cmd_t      cmd_i,
  output psra_pkg::cmd_t      cmd_o,
  output psra_pkg::q_stat_t   stat_o
);

  psra_pkg::cmd_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (ctrl_i.push) wr_ptr_q <= ~wr_ptr_q;
      if (ctrl_i.pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, ctrl_i.push} - {1'b0, ctrl_i.pop};
    end
  end

  assign cmd_o        = slot_q[rd_ptr_q];
  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !ctrl_i.push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.empty |-> !ctrl_i.pop)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");

endmodule
`default_nettype wire

// File: hdl/psra_back.sv
// Back end: sensor table, sample memory, window sum and divide by the window length.
`default_nettype none
module psra_back #(
  parameter int unsigned WINDOW_LEN  = 5,
  parameter int unsigned MAX_SENSORS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  psra_pkg::cmd_t                     cmd_i,
  input  wire logic                          cmd_valid_i,
  output logic                               pop_o,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [psra_pkg::IdW-1:0]           room_of_sensor_o,
  output logic signed [psra_pkg::ValueW-1:0] average_o,
  output logic                               window_full_o
);

  localparam int unsigned EB   = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int unsigned CB   = $clog2(MAX_SENSORS + 1);
  localparam int unsigned SW   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned FW   = $clog2(WINDOW_LEN + 1);
  localparam int unsigned DEP  = MAX_SENSORS * WINDOW_LEN;
  localparam int unsigned AW   = (DEP > 1) ? $clog2(DEP) : 1;
  localparam int unsigned SUMW = psra_pkg::ValueW + $clog2(WINDOW_LEN) + 1;
  localparam int unsigned LB   = $clog2(WINDOW_LEN);
  localparam int unsigned RS   = SUMW + LB;
  localparam int unsigned MW   = RS + 1;
  localparam int unsigned PW   = SUMW + MW;
  localparam logic [FW-1:0]  WinLen  = FW'(WINDOW_LEN);
  localparam logic [SW-1:0]  LastSlot = SW'(WINDOW_LEN - 1);
  localparam logic [MW-1:0]  Recip   =
    MW'(((64'd1 << RS) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
  localparam logic [CB-1:0]  MaxCnt  = CB'(MAX_SENSORS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOOK = 6'b000010,
    S_SUM  = 6'b000100,
    S_PREP = 6'b001000,
    S_DIV  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic                       valid_q  [MAX_SENSORS];
  logic [psra_pkg::IdW-1:0]   sensor_q [MAX_SENSORS];
  logic [psra_pkg::IdW-1:0]   room_q   [MAX_SENSORS];
  logic [FW-1:0]              fill_q   [MAX_SENSORS];
  logic [SW-1:0]              oldest_q [MAX_SENSORS];
  logic [CB-1:0]              loaded_q;

  logic signed [psra_pkg::ValueW-1:0] mem [DEP];
  logic signed [psra_pkg::ValueW-1:0] rdata_q;

  psra_pkg::cmd_t       cmd_q;
  logic [EB-1:0]        ent_q;
  logic [AW-1:0]        base_q;
  logic [FW-1:0]        cnt_q;
  logic signed [SUMW-1:0] acc_q;
  logic [SUMW-1:0]      mag_q;
  logic                 neg_q;
  logic [PW-1:0]        prod_q;

  logic                 done_q;
  logic [1:0]           status_q;
  logic [psra_pkg::IdW-1:0] room_out_q;
  logic signed [psra_pkg::ValueW-1:0] avg_q;
  logic                 full_q;

  // Lookup: highest matching index wins, which is the entry loaded last.
  logic          hit;
  logic [EB-1:0] hit_idx;
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < MAX_SENSORS; i++) begin
      if (valid_q[i] && sensor_q[i] == cmd_q.sensor) begin
        hit     = 1'b1;
        hit_idx = EB'(i);
      end
    end
  end

  logic [FW-1:0] sel_fill;
  logic [SW-1:0] sel_oldest, slot;
  logic          was_full;
  logic [FW-1:0] new_fill;
  logic [AW-1:0] look_base, wr_addr, rd_addr;
  assign sel_fill   = fill_q[hit_idx];
  assign sel_oldest = oldest_q[hit_idx];
  assign was_full   = (sel_fill >= WinLen);
  assign slot       = was_full ? sel_oldest : sel_fill[SW-1:0];
  assign new_fill   = was_full ? sel_fill : sel_fill + FW'(1);
  assign look_base  = AW'(AW'(hit_idx) * AW'(WINDOW_LEN));
  assign wr_addr    = look_base + AW'(slot);
  assign rd_addr    = base_q + AW'(cnt_q);

  logic mem_we;
  assign mem_we = (state_q == S_LOOK) && hit;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= cmd_q.value;
    end
    rdata_q <= mem[rd_addr];
  end

  logic signed [SUMW-1:0] acc_next;
  assign acc_next = acc_q + SUMW'(rdata_q);

  assign pop_o = (state_q == S_IDLE) && cmd_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (cmd_valid_i && cmd_i.kind == psra_pkg::CMD_READ) state_d = S_LOOK;
      S_LOOK: if (hit && new_fill == WinLen) state_d = S_SUM;
              else state_d = S_IDLE;
      S_SUM:  if (cnt_q == WinLen) state_d = S_PREP;
      S_PREP: state_d = S_DIV;
      S_DIV:  state_d = S_FIN;
      S_FIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      loaded_q <= '0;
      done_q   <= 1'b0;
      for (int i = 0; i < MAX_SENSORS; i++) begin
        valid_q[i]  <= 1'b0;
        fill_q[i]   <= '0;
        oldest_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i && cmd_i.kind == psra_pkg::CMD_LOAD) begin
            done_q <= 1'b1;
            if (loaded_q < MaxCnt) begin
              valid_q[loaded_q[EB-1:0]]  <= 1'b1;
              fill_q[loaded_q[EB-1:0]]   <= '0;
              oldest_q[loaded_q[EB-1:0]] <= '0;
              loaded_q <= loaded_q + CB'(1);
            end
          end else if (cmd_valid_i && cmd_i.kind == psra_pkg::CMD_REJECT) begin
            done_q <= 1'b1;
          end
        end
        S_LOOK: begin
          if (!hit || new_fill != WinLen) done_q <= 1'b1;
          if (hit) begin
            fill_q[hit_idx] <= new_fill;
            if (was_full) oldest_q[hit_idx] <= (slot == LastSlot) ? '0 : slot + SW'(1);
          end
        end
        S_FIN: done_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Entry ids, rooms and the datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        cmd_q <= cmd_i;
        room_out_q <= '0;
        avg_q      <= '0;
        full_q     <= 1'b0;
        if (cmd_i.kind == psra_pkg::CMD_LOAD) begin
          if (loaded_q < MaxCnt) begin
            sensor_q[loaded_q[EB-1:0]] <= cmd_i.sensor;
            room_q[loaded_q[EB-1:0]]   <= cmd_i.room;
            status_q   <= psra_pkg::StatusOk;
            room_out_q <= cmd_i.room;
          end else begin
            status_q <= psra_pkg::StatusFull;
          end
        end else begin
          status_q <= psra_pkg::StatusRange;
        end
      end
      S_LOOK: begin
        ent_q  <= hit_idx;
        base_q <= look_base;
        cnt_q  <= '0;
        acc_q  <= '0;
        if (hit) begin
          status_q   <= psra_pkg::StatusOk;
          room_out_q <= room_q[hit_idx];
        end else begin
          status_q <= psra_pkg::StatusUnknown;
        end
      end
      S_SUM: begin
        cnt_q <= cnt_q + FW'(1);
        if (cnt_q != '0) acc_q <= acc_next;
      end
      S_PREP: begin
        neg_q  <= acc_q[SUMW-1];
        mag_q  <= acc_q[SUMW-1] ? SUMW'(-acc_q) : acc_q;
      end
      // The divide is a multiply by the rounded-up reciprocal of the window length;
      // the extra LB fraction bits make the quotient exact for every sum magnitude.
      S_DIV: begin
        prod_q <= PW'(mag_q) * PW'(Recip);
      end
      S_FIN: begin
        room_out_q <= room_q[ent_q];
        full_q     <= 1'b1;
        avg_q      <= neg_q ? -prod_q[RS +: psra_pkg::ValueW] :
                              prod_q[RS +: psra_pkg::ValueW];
      end
      default: ;
    endcase
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign room_of_sensor_o = room_out_q;
  assign average_o        = avg_q;
  assign window_full_o    = full_q;

  a_loaded_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= MaxCnt)
    else $error("entry count above table size");
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SUM |-> cnt_q <= WinLen)
    else $error("window read index out of range");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && status_q != psra_pkg::StatusOk |->
      room_out_q == '0 && avg_q == '0 && !full_q)
    else $error("failed item carries payload");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> !(state_q == S_SUM || state_q == S_DIV || state_q == S_FIN))
    else $error("back end left idle on a quick command");

endmodule
`default_nettype wire

// File: hdl/per_sensor_running_average.sv
// Top level of the per-sensor running average block.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------------
//  command  | start / busy           | mode_i sensor_id_i room_i reading_value_i timestamp_i
//  result   | done_o (one cycle)     | status_o room_of_sensor_o average_o window_full_o
//  config   | cfg_valid_i/cfg_ready_o| cfg_index_i cfg_data_i
//
// A load, a range rejection, an unknown id or a reading short of a full window gives its
// result from the back end's idle or lookup state. A reading that fills the window goes on
// through the window sum, with one sample memory read per cycle, and a registered
// reciprocal multiply for the divide. A two-entry queue holds commands; busy is high
// while it is full. Reset clears the table and loads the default limits; no clearing pass.
`default_nettype none
module per_sensor_running_average #(
  parameter int unsigned WINDOW_LEN  = 5,
  parameter int unsigned MAX_SENSORS = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                mode_i,
  input  wire logic [psra_pkg::IdW-1:0]            sensor_id_i,
  input  wire logic [psra_pkg::IdW-1:0]            room_i,
  input  wire logic signed [psra_pkg::ValueW-1:0]  reading_value_i,
  input  wire logic [psra_pkg::TimeW-1:0]          timestamp_i,
  output logic                                     done_o,
  output logic [1:0]                               status_o,
  output logic [psra_pkg::IdW-1:0]                 room_of_sensor_o,
  output logic signed [psra_pkg::ValueW-1:0]       average_o,
  output logic                                     window_full_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [1:0]                          cfg_index_i,
  input  wire logic [psra_pkg::TimeW-1:0]          cfg_data_i
);

  psra_pkg::cmd_t    front_cmd, queue_cmd;
  psra_pkg::q_ctrl_t q_ctrl;
  psra_pkg::q_stat_t q_stat;
  logic              accept, pop;

  assign busy        = q_stat.full;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  psra_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .mode_i,
    .sensor_id_i,
    .room_i,
    .reading_value_i,
    .timestamp_i,
    .cmd_o    (front_cmd)
  );

  assign q_ctrl.push = accept;
  assign q_ctrl.pop  = pop;

  psra_queue u_queue (
    .clk_i,
    .rst_ni,
    .ctrl_i (q_ctrl),
    .cmd_i  (front_cmd),
    .cmd_o  (queue_cmd),
    .stat_o (q_stat)
  );

  psra_back #(
    .WINDOW_LEN  (WINDOW_LEN),
    .MAX_SENSORS (MAX_SENSORS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cmd_i            (queue_cmd),
    .cmd_valid_i      (!q_stat.empty),
    .pop_o            (pop),
    .done_o,
    .status_o,
    .room_of_sensor_o,
    .average_o,
    .window_full_o
  );

endmodule
`default_nettype wire
